/* src/lru_hit_count_admission_assert.svh */
// Assertion shorthands shared by the admission filter RTL.
// Both expect clk and rst_n in scope.
`ifndef LRU_HIT_COUNT_ADMISSION_ASSERT_SVH
`define LRU_HIT_COUNT_ADMISSION_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define LHCA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define LHCA_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* src/lhca_pkg.sv */
`default_nettype none

package lhca_pkg;

    // configuration register indexes and widths
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int LIMIT_BITS    = 11;
    localparam int THRESH_BITS   = 16;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LIMIT  = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_THRESH = 2'd2;

    localparam logic                   RESET_MODE   = 1'b1;
    localparam logic [LIMIT_BITS-1:0]  RESET_LIMIT  = 11'd1000;
    localparam logic [THRESH_BITS-1:0] RESET_THRESH = 16'd10;
    localparam int                     MIN_BUCKETS  = 10;

    // reduction tree fan-in at its first stage
    localparam int GROUP = 16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GROUP,
        S_MERGE,
        S_APPLY
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_FRONT,
        OP_PULL
    } cell_op_t;

    typedef struct packed {
        logic     probe;
        cell_op_t op;
    } cell_cmd_t;

endpackage

`default_nettype wire

/* src/lhca_cell.sv */
`default_nettype none

// One rank of the recency list. Cell 0 is most recent.
module lhca_cell #(
    parameter int IDX        = 0,
    parameter int KEY_BITS   = 64,
    parameter int COUNT_BITS = 16,
    parameter int IDX_W      = 10,
    parameter int OCC_W      = 11
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire lhca_pkg::cell_cmd_t    cmd,
    input  wire logic [IDX_W-1:0]       sel,
    input  wire logic [OCC_W-1:0]       occ,
    input  wire logic [KEY_BITS-1:0]    req_key,
    input  wire logic [KEY_BITS-1:0]    head_key,
    input  wire logic [COUNT_BITS-1:0]  head_count,
    input  wire logic [KEY_BITS-1:0]    prev_key,
    input  wire logic [COUNT_BITS-1:0]  prev_count,
    input  wire logic [KEY_BITS-1:0]    next_key,
    input  wire logic [COUNT_BITS-1:0]  next_count,
    output logic [KEY_BITS-1:0]         entry_key,
    output logic [COUNT_BITS-1:0]       entry_count,
    output logic                        hit
);

    localparam logic [IDX_W-1:0] POS     = IDX_W'(IDX);
    localparam logic [OCC_W-1:0] POS_OCC = OCC_W'(IDX);

    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   key_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  hit_reg;
    logic                  valid;

    // occupancy is contiguous from rank 0
    assign valid = POS_OCC < occ;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.probe)
        begin
            hit_reg <= valid && (key_reg == req_key);
        end
    end

    always_comb
    begin
        key_next   = key_reg;
        count_next = count_reg;
        case (cmd.op)
            lhca_pkg::OP_FRONT:
            begin
                if (POS == '0)
                begin
                    key_next   = head_key;
                    count_next = head_count;
                end
                else if (POS <= sel)
                begin
                    key_next   = prev_key;
                    count_next = prev_count;
                end
            end
            lhca_pkg::OP_PULL:
            begin
                if (POS >= sel)
                begin
                    key_next   = next_key;
                    count_next = next_count;
                end
            end
            default:
            begin
                key_next   = key_reg;
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        count_reg <= count_next;
    end

    assign entry_key   = key_reg;
    assign entry_count = count_reg;
    assign hit         = hit_reg;

endmodule

`default_nettype wire

/* src/lhca_tree.sv */
`default_nettype none

// Two-stage registered encoder of the one-hot hit vector: rank and count of the hit.
module lhca_tree #(
    parameter int DEPTH      = 1024,
    parameter int IDX_W      = 10,
    parameter int COUNT_BITS = 16
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire logic [DEPTH-1:0]       hit,
    input  wire logic [COUNT_BITS-1:0]  counts [DEPTH],
    output logic                        found,
    output logic [IDX_W-1:0]            idx,
    output logic [COUNT_BITS-1:0]       count
);

    localparam int GROUP = lhca_pkg::GROUP;
    localparam int NGRP  = DEPTH / GROUP;

    logic                  grp_any     [NGRP];
    logic [IDX_W-1:0]      grp_idx     [NGRP];
    logic [COUNT_BITS-1:0] grp_cnt     [NGRP];
    logic                  grp_any_reg [NGRP];
    logic [IDX_W-1:0]      grp_idx_reg [NGRP];
    logic [COUNT_BITS-1:0] grp_cnt_reg [NGRP];

    logic                  found_next;
    logic [IDX_W-1:0]      idx_next;
    logic [COUNT_BITS-1:0] count_next;
    logic                  found_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [COUNT_BITS-1:0] count_reg;

    // at most one hit, so OR-ing masked fields yields the hit's fields
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_any[g] = 1'b0;
            grp_idx[g] = '0;
            grp_cnt[g] = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                if (hit[g*GROUP + j])
                begin
                    grp_any[g] = 1'b1;
                    grp_idx[g] = grp_idx[g] | IDX_W'(g*GROUP + j);
                    grp_cnt[g] = grp_cnt[g] | counts[g*GROUP + j];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < NGRP; g++)
            begin
                grp_any_reg[g] <= 1'b0;
            end
            found_reg <= 1'b0;
        end
        else
        begin
            for (int g = 0; g < NGRP; g++)
            begin
                grp_any_reg[g] <= grp_any[g];
            end
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_idx_reg[g] <= grp_idx[g];
            grp_cnt_reg[g] <= grp_cnt[g];
        end
        idx_reg   <= idx_next;
        count_reg <= count_next;
    end

    always_comb
    begin
        found_next = 1'b0;
        idx_next   = '0;
        count_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            found_next = found_next | grp_any_reg[g];
            idx_next   = idx_next | grp_idx_reg[g];
            count_next = count_next | grp_cnt_reg[g];
        end
    end

    assign found = found_reg;
    assign idx   = idx_reg;
    assign count = count_reg;

endmodule

`default_nettype wire

/* src/lru_hit_count_admission.sv */
`default_nettype none

// Cache admission filter with LRU hit counting.
// Request: drive key and sampled with start; it is taken at a clock edge where
// start is high and busy is low. Each request yields exactly one result, shown
// for one cycle on promote, was_present, evicted and hit_count with done high.
// The receiver cannot stall; it must take the result in that cycle.
// Unsampled requests and requests in chance mode answer in the cycle after
// acceptance and leave busy low. An LRU lookup runs through the per-cell key
// compare, the registered stages of the hit encoder and the table update;
// busy stays high from acceptance until the update. A new request may be
// issued in the cycle done is shown. The table is a chain of cells ordered by
// recency; updates shift the chain by one rank. Configuration: cfg_wr with
// cfg_addr/cfg_data writes a register at the clock edge. The user must write
// only while busy is low and no result is pending; the block does not check.
// Reset empties the table and loads policy LRU, limit 1000, threshold 10.
// TABLE_DEPTH must be a multiple of 16.
module lru_hit_count_admission #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BITS    = 64,
    parameter int COUNT_BITS  = 16
) (
    input  wire                                      clk,
    input  wire                                      rst_n,
    input  wire                                      start,
    output logic                                     busy,
    input  wire logic [KEY_BITS-1:0]                 key,
    input  wire                                      sampled,
    output logic                                     done,
    output logic                                     promote,
    output logic                                     was_present,
    output logic                                     evicted,
    output logic [COUNT_BITS-1:0]                    hit_count,
    input  wire                                      cfg_wr,
    input  wire logic [lhca_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  wire logic [lhca_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int OCC_W = $clog2(TABLE_DEPTH + 1);
    localparam int LIM_W = (OCC_W > lhca_pkg::LIMIT_BITS) ? OCC_W : lhca_pkg::LIMIT_BITS;
    localparam int CMP_W = (COUNT_BITS > lhca_pkg::THRESH_BITS) ? COUNT_BITS
                                                                : lhca_pkg::THRESH_BITS;

    lhca_pkg::state_t state_reg;
    lhca_pkg::state_t state_next;

    logic                               mode_reg;
    logic [lhca_pkg::LIMIT_BITS-1:0]    limit_reg;
    logic [lhca_pkg::THRESH_BITS-1:0]   thr_reg;
    logic [OCC_W-1:0]                   occ_reg;
    logic [OCC_W-1:0]                   occ_next;
    logic [KEY_BITS-1:0]                key_reg;

    logic                  done_reg;
    logic                  done_next;
    logic                  promote_reg;
    logic                  promote_next;
    logic                  present_reg;
    logic                  present_next;
    logic                  evicted_reg;
    logic                  evicted_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;

    logic                  accept;
    lhca_pkg::cell_cmd_t   cell_cmd;
    logic [IDX_W-1:0]      sel;
    logic [COUNT_BITS-1:0] head_cnt;

    logic [TABLE_DEPTH-1:0] hit_vec;
    logic [KEY_BITS-1:0]    cell_key   [TABLE_DEPTH];
    logic [COUNT_BITS-1:0]  cell_cnt   [TABLE_DEPTH];
    logic [KEY_BITS-1:0]    prev_key   [TABLE_DEPTH];
    logic [COUNT_BITS-1:0]  prev_cnt   [TABLE_DEPTH];
    logic [KEY_BITS-1:0]    next_key   [TABLE_DEPTH];
    logic [COUNT_BITS-1:0]  next_cnt   [TABLE_DEPTH];

    logic                  tree_found;
    logic [IDX_W-1:0]      tree_idx;
    logic [COUNT_BITS-1:0] tree_cnt;

    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  reach_thr;
    logic [LIM_W-1:0]      lim_ext;
    logic [LIM_W-1:0]      eff_limit;
    logic                  full;
    logic [OCC_W-1:0]      occ_less;
    logic                  idx_in_range;

    assign accept = start && !busy;

    // ---- configuration registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= lhca_pkg::RESET_MODE;
            limit_reg <= lhca_pkg::RESET_LIMIT;
            thr_reg   <= lhca_pkg::RESET_THRESH;
        end
        else if (cfg_wr)
        begin
            case (cfg_addr)
                lhca_pkg::CFG_MODE:   mode_reg  <= cfg_data[0];
                lhca_pkg::CFG_LIMIT:  limit_reg <= cfg_data[lhca_pkg::LIMIT_BITS-1:0];
                lhca_pkg::CFG_THRESH: thr_reg   <= cfg_data[lhca_pkg::THRESH_BITS-1:0];
                default:              mode_reg  <= mode_reg;
            endcase
        end
    end

    // ---- recency chain ----
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign prev_key[i] = key_reg;
            assign prev_cnt[i] = head_cnt;
        end
        else
        begin : g_body
            assign prev_key[i] = cell_key[i-1];
            assign prev_cnt[i] = cell_cnt[i-1];
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_tail
            assign next_key[i] = cell_key[i];
            assign next_cnt[i] = cell_cnt[i];
        end
        else
        begin : g_inner
            assign next_key[i] = cell_key[i+1];
            assign next_cnt[i] = cell_cnt[i+1];
        end

        lhca_cell #(
            .IDX        (i),
            .KEY_BITS   (KEY_BITS),
            .COUNT_BITS (COUNT_BITS),
            .IDX_W      (IDX_W),
            .OCC_W      (OCC_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cell_cmd),
            .sel         (sel),
            .occ         (occ_reg),
            .req_key     (key),
            .head_key    (key_reg),
            .head_count  (head_cnt),
            .prev_key    (prev_key[i]),
            .prev_count  (prev_cnt[i]),
            .next_key    (next_key[i]),
            .next_count  (next_cnt[i]),
            .entry_key   (cell_key[i]),
            .entry_count (cell_cnt[i]),
            .hit         (hit_vec[i])
        );
    end

    lhca_tree #(
        .DEPTH      (TABLE_DEPTH),
        .IDX_W      (IDX_W),
        .COUNT_BITS (COUNT_BITS)
    ) u_tree (
        .clk    (clk),
        .rst_n  (rst_n),
        .hit    (hit_vec),
        .counts (cell_cnt),
        .found  (tree_found),
        .idx    (tree_idx),
        .count  (tree_cnt)
    );

    // ---- update decision ----
    assign cnt_inc   = (&tree_cnt) ? tree_cnt : tree_cnt + COUNT_BITS'(1);
    assign reach_thr = CMP_W'(cnt_inc) >= CMP_W'(thr_reg);
    assign lim_ext   = LIM_W'(limit_reg);

    always_comb
    begin
        if (lim_ext < LIM_W'(lhca_pkg::MIN_BUCKETS))
        begin
            eff_limit = LIM_W'(lhca_pkg::MIN_BUCKETS);
        end
        else if (lim_ext > LIM_W'(TABLE_DEPTH))
        begin
            eff_limit = LIM_W'(TABLE_DEPTH);
        end
        else
        begin
            eff_limit = lim_ext;
        end
    end

    assign full         = LIM_W'(occ_reg) >= eff_limit;
    assign occ_less     = occ_reg - OCC_W'(1);
    assign idx_in_range = OCC_W'(tree_idx) < occ_reg;

    // ---- control ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lhca_pkg::S_IDLE;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= key;
        end
        promote_reg <= promote_next;
        present_reg <= present_next;
        evicted_reg <= evicted_next;
        count_reg   <= count_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        done_next      = 1'b0;
        promote_next   = promote_reg;
        present_next   = present_reg;
        evicted_next   = evicted_reg;
        count_next     = count_reg;
        cell_cmd.probe = 1'b0;
        cell_cmd.op    = lhca_pkg::OP_HOLD;
        sel            = '0;
        head_cnt       = COUNT_BITS'(1);
        case (state_reg)
            lhca_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cell_cmd.probe = 1'b1;
                    if (!sampled || !mode_reg)
                    begin
                        // answered at once, table untouched
                        done_next    = 1'b1;
                        promote_next = sampled;
                        present_next = 1'b0;
                        evicted_next = 1'b0;
                        count_next   = '0;
                    end
                    else
                    begin
                        state_next = lhca_pkg::S_GROUP;
                    end
                end
            end
            lhca_pkg::S_GROUP:
            begin
                state_next = lhca_pkg::S_MERGE;
            end
            lhca_pkg::S_MERGE:
            begin
                state_next = lhca_pkg::S_APPLY;
            end
            lhca_pkg::S_APPLY:
            begin
                state_next   = lhca_pkg::S_IDLE;
                done_next    = 1'b1;
                present_next = tree_found;
                evicted_next = 1'b0;
                promote_next = 1'b0;
                if (tree_found)
                begin
                    count_next = cnt_inc;
                    sel        = tree_idx;
                    if (reach_thr)
                    begin
                        // promoted: close the gap behind it
                        promote_next = 1'b1;
                        cell_cmd.op  = lhca_pkg::OP_PULL;
                        occ_next     = occ_less;
                    end
                    else
                    begin
                        cell_cmd.op = lhca_pkg::OP_FRONT;
                        head_cnt    = cnt_inc;
                    end
                end
                else
                begin
                    count_next  = COUNT_BITS'(1);
                    cell_cmd.op = lhca_pkg::OP_FRONT;
                    if (full)
                    begin
                        // least recent drops off the end
                        evicted_next = 1'b1;
                        sel          = occ_less[IDX_W-1:0];
                    end
                    else
                    begin
                        sel      = occ_reg[IDX_W-1:0];
                        occ_next = occ_reg + OCC_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = lhca_pkg::S_IDLE;
            end
        endcase
    end

    assign busy        = state_reg != lhca_pkg::S_IDLE;
    assign done        = done_reg;
    assign promote     = promote_reg;
    assign was_present = present_reg;
    assign evicted     = evicted_reg;
    assign hit_count   = count_reg;

`include "lru_hit_count_admission_assert.svh"

    `LHCA_ASSERT(a_hit_onehot, $onehot0(hit_vec), "several cells matched one key")
    `LHCA_ASSERT(a_occ_bound, occ_reg <= OCC_W'(TABLE_DEPTH), "occupancy beyond table depth")
    `LHCA_IMPLY(a_done_idle, done_reg, !busy, "result shown while a lookup is running")
    `LHCA_IMPLY(a_evict_miss, done_reg && evicted_reg, !present_reg && !promote_reg, "eviction on a hit or with promotion")
    `LHCA_IMPLY(a_hit_rank, state_reg == lhca_pkg::S_APPLY && tree_found, idx_in_range, "hit rank outside occupied entries")

endmodule

`default_nettype wire

/* dv/testbench.sv */
module testbench;

    localparam int KEY_W     = 64;
    localparam int CNT_W     = 16;
    localparam int DEPTH     = 1024;
    localparam int SETTLE    = 8;
    localparam int MAX_SHOWN = 10;

    typedef struct {
        bit                                 is_write;
        logic [lhca_pkg::CFG_ADDR_BITS-1:0] addr;
        logic [lhca_pkg::CFG_DATA_BITS-1:0] data;
        logic [KEY_W-1:0]                   key;
        logic                               sampled;
        int unsigned                        idle_pct;
    } admit_req_t;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic             promote;
        logic             was_present;
        logic             evicted;
        logic [CNT_W-1:0] hit_count;
    } verdict_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               start = 1'b0;
    logic                               busy;
    logic [KEY_W-1:0]                   key = '0;
    logic                               sampled = 1'b0;
    logic                               done;
    logic                               promote;
    logic                               was_present;
    logic                               evicted;
    logic [CNT_W-1:0]                   hit_count;
    logic                               cfg_wr = 1'b0;
    logic [lhca_pkg::CFG_ADDR_BITS-1:0] cfg_addr = lhca_pkg::CFG_MODE;
    logic [lhca_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

    lru_hit_count_admission dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .key         (key),
        .sampled     (sampled),
        .done        (done),
        .promote     (promote),
        .was_present (was_present),
        .evicted     (evicted),
        .hit_count   (hit_count),
        .cfg_wr      (cfg_wr),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the recency table: index 0 is the most recent entry
    logic [KEY_W-1:0]                 lru_keys[$];
    logic [CNT_W-1:0]                 lru_counts[$];
    logic                             mode_r = lhca_pkg::RESET_MODE;
    logic [lhca_pkg::LIMIT_BITS-1:0]  limit_r = lhca_pkg::RESET_LIMIT;
    logic [lhca_pkg::THRESH_BITS-1:0] thresh_r = lhca_pkg::RESET_THRESH;

    admit_req_t  pending_reqs[$];
    verdict_t    expected_verdicts[$];
    int unsigned sender_idle;
    int          n_sent;
    int          n_got;
    int          quiet;
    int          failures = 0;

    function automatic verdict_t admit_predict(logic [KEY_W-1:0] k, logic s);
        verdict_t         v;
        int               hit_at;
        int               cap;
        logic [CNT_W-1:0] c;
        v.key         = k;
        v.promote     = 1'b0;
        v.was_present = 1'b0;
        v.evicted     = 1'b0;
        v.hit_count   = '0;
        hit_at        = -1;
        if (s && !mode_r)
        begin
            v.promote = 1'b1;
        end
        else if (s)
        begin
            for (int i = 0; i < lru_keys.size(); i++)
            begin
                if (lru_keys[i] == k)
                begin
                    hit_at = i;
                    break;
                end
            end
            if (hit_at >= 0)
            begin
                c = lru_counts[hit_at];
                if (c != {CNT_W{1'b1}})
                    c = c + 1'b1;
                v.was_present = 1'b1;
                v.hit_count   = c;
                lru_keys.delete(hit_at);
                lru_counts.delete(hit_at);
                if (c >= thresh_r)
                begin
                    v.promote = 1'b1;
                end
                else
                begin
                    lru_keys.insert(0, k);
                    lru_counts.insert(0, c);
                end
            end
            else
            begin
                cap = int'(limit_r);
                if (cap < lhca_pkg::MIN_BUCKETS)
                    cap = lhca_pkg::MIN_BUCKETS;
                if (cap > DEPTH)
                    cap = DEPTH;
                // occupancy above a lowered limit only shrinks through promotions
                if (lru_keys.size() >= cap)
                begin
                    v.evicted = 1'b1;
                    void'(lru_keys.pop_back());
                    void'(lru_counts.pop_back());
                end
                lru_keys.insert(0, k);
                lru_counts.insert(0, CNT_W'(1));
                v.hit_count = CNT_W'(1);
            end
        end
        return v;
    endfunction

    function automatic void set_register(logic [lhca_pkg::CFG_ADDR_BITS-1:0] a,
                                         logic [lhca_pkg::CFG_DATA_BITS-1:0] d);
        case (a)
            lhca_pkg::CFG_MODE:   mode_r   = d[0];
            lhca_pkg::CFG_LIMIT:  limit_r  = d[lhca_pkg::LIMIT_BITS-1:0];
            lhca_pkg::CFG_THRESH: thresh_r = d[lhca_pkg::THRESH_BITS-1:0];
            default:              ;
        endcase
    endfunction

    function automatic void queue_request(logic [KEY_W-1:0] k, logic s);
        admit_req_t r;
        r.is_write = 1'b0;
        r.addr     = lhca_pkg::CFG_MODE;
        r.data     = '0;
        r.key      = k;
        r.sampled  = s;
        r.idle_pct = sender_idle;
        pending_reqs.push_back(r);
    endfunction

    function automatic void queue_write(logic [lhca_pkg::CFG_ADDR_BITS-1:0] a,
                                        logic [lhca_pkg::CFG_DATA_BITS-1:0] d);
        admit_req_t r;
        r.is_write = 1'b1;
        r.addr     = a;
        r.data     = d;
        r.key      = '0;
        r.sampled  = 1'b0;
        r.idle_pct = 0;
        pending_reqs.push_back(r);
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    // driver: predicts each transaction as it is taken
    logic                               taken;
    logic                               nxt_start;
    logic                               nxt_cfg;
    logic [KEY_W-1:0]                   nxt_key;
    logic                               nxt_sampled;
    logic [lhca_pkg::CFG_ADDR_BITS-1:0] nxt_addr;
    logic [lhca_pkg::CFG_DATA_BITS-1:0] nxt_data;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            key      <= '0;
            sampled  <= 1'b0;
            cfg_wr   <= 1'b0;
            cfg_addr <= lhca_pkg::CFG_MODE;
            cfg_data <= '0;
            n_sent   <= 0;
            quiet    <= 0;
            lru_keys.delete();
            lru_counts.delete();
            mode_r   = lhca_pkg::RESET_MODE;
            limit_r  = lhca_pkg::RESET_LIMIT;
            thresh_r = lhca_pkg::RESET_THRESH;
        end
        else
        begin
            taken       = start && !busy;
            nxt_start   = start && !taken;
            nxt_cfg     = 1'b0;
            nxt_key     = key;
            nxt_sampled = sampled;
            nxt_addr    = cfg_addr;
            nxt_data    = cfg_data;
            if (taken)
            begin
                expected_verdicts.push_back(admit_predict(key, sampled));
                n_sent <= n_sent + 1;
            end
            if (!nxt_start && pending_reqs.size() != 0)
            begin
                if (pending_reqs[0].is_write)
                begin
                    // registers change only with the block drained and quiet
                    if (!start && n_sent == n_got && quiet >= SETTLE)
                    begin
                        set_register(pending_reqs[0].addr, pending_reqs[0].data);
                        nxt_cfg  = 1'b1;
                        nxt_addr = pending_reqs[0].addr;
                        nxt_data = pending_reqs[0].data;
                        void'(pending_reqs.pop_front());
                    end
                end
                else if ($urandom_range(99) >= pending_reqs[0].idle_pct)
                begin
                    nxt_start   = 1'b1;
                    nxt_key     = pending_reqs[0].key;
                    nxt_sampled = pending_reqs[0].sampled;
                    void'(pending_reqs.pop_front());
                end
            end
            if (start || busy || done || n_sent != n_got)
                quiet <= 0;
            else if (quiet < SETTLE)
                quiet <= quiet + 1;
            start    <= nxt_start;
            key      <= nxt_key;
            sampled  <= nxt_sampled;
            cfg_wr   <= nxt_cfg;
            cfg_addr <= nxt_addr;
            cfg_data <= nxt_data;
        end
    end

    verdict_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_got <= 0;
        end
        else if (done)
        begin
            n_got <= n_got + 1;
            if (expected_verdicts.size() == 0)
            begin
                if (failures < MAX_SHOWN)
                    $display("unexpected result: promote %b present %b evicted %b count %0d",
                             promote, was_present, evicted, hit_count);
                failures++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (promote !== want.promote || was_present !== want.was_present ||
                    evicted !== want.evicted || hit_count !== want.hit_count)
                begin
                    if (failures < MAX_SHOWN)
                    begin
                        $display("mismatch for key %h", want.key);
                        $display("  expected promote %b present %b evicted %b count %0d",
                                 want.promote, want.was_present, want.evicted,
                                 want.hit_count);
                        $display("  actual   promote %b present %b evicted %b count %0d",
                                 promote, was_present, evicted, hit_count);
                    end
                    failures++;
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [KEY_W-1:0]                 pool[$];
        logic [KEY_W-1:0]                 k;
        logic [lhca_pkg::LIMIT_BITS-1:0]  lim;
        logic [lhca_pkg::THRESH_BITS-1:0] thr;
        logic                             m;
        int                               b;
        int                               n_random;
        int                               pool_size;
        int                               phase_len;

        // directed: field extremes, both modes, threshold zero, minimum limit
        sender_idle = 9;
        queue_request({KEY_W{1'b1}}, 1'b0);
        queue_request({KEY_W{1'b0}}, 1'b0);
        queue_request({KEY_W{1'b0}}, 1'b1);
        queue_request({KEY_W{1'b1}}, 1'b1);
        queue_request({KEY_W{1'b0}}, 1'b1);
        queue_request({1'b1, {(KEY_W-1){1'b0}}}, 1'b1);
        queue_request({{(KEY_W-1){1'b0}}, 1'b1}, 1'b1);
        queue_request({KEY_W{1'b0}}, 1'b0);
        queue_write(lhca_pkg::CFG_THRESH, 16'd0);
        queue_request({KEY_W{1'b1}}, 1'b1);
        queue_request({KEY_W{1'b1}}, 1'b1);
        queue_write(lhca_pkg::CFG_MODE, 16'hFFFE);
        queue_request({KEY_W{1'b0}}, 1'b1);
        queue_request({KEY_W{1'b0}}, 1'b0);
        queue_write(lhca_pkg::CFG_MODE, 16'h0001);
        queue_write(lhca_pkg::CFG_THRESH, 16'd3);
        queue_write(lhca_pkg::CFG_LIMIT, 16'd0);
        queue_request({KEY_W{1'b0}}, 1'b1);
        repeat (11) queue_request(random_key(), 1'b1);

        // random phases over small key pools so that hits and promotions occur
        n_random = 0;
        while (n_random < 1120)
        begin
            sender_idle = (n_random < 373) ? 9 : (n_random < 746) ? 49 : 0;
            k = random_key();
            m = ($urandom_range(99) < 85);
            queue_write(lhca_pkg::CFG_MODE, {k[15:1], m});
            case ($urandom_range(5))
                0:       lim = 11'($urandom_range(0, 9));
                1:       lim = 11'd10;
                2, 5:    lim = 11'($urandom_range(10, 64));
                3:       lim = 11'd1024;
                default: lim = 11'($urandom_range(1025, 2047));
            endcase
            queue_write(lhca_pkg::CFG_LIMIT, {k[31:27], lim});
            case ($urandom_range(5))
                0:       thr = '0;
                1:       thr = 16'd1;
                2, 3:    thr = 16'($urandom_range(2, 8));
                4:       thr = k[63:48];
                default: thr = '1;
            endcase
            queue_write(lhca_pkg::CFG_THRESH, thr);
            pool.delete();
            pool_size = int'($urandom_range(4, 48));
            for (int i = 0; i < pool_size; i++)
            begin
                // neighbours one bit apart catch partial key compares
                if (i > 0 && $urandom_range(3) == 0)
                begin
                    k = pool[i-1];
                    b = int'($urandom_range(KEY_W-1));
                    k[b] = ~k[b];
                end
                else if ($urandom_range(15) == 0)
                begin
                    k = ($urandom_range(1) == 0) ? {KEY_W{1'b0}} : {KEY_W{1'b1}};
                end
                else
                begin
                    k = random_key();
                end
                pool.push_back(k);
            end
            phase_len = int'($urandom_range(60, 100));
            for (int i = 0; i < phase_len; i++)
            begin
                k = ($urandom_range(9) == 0) ? random_key() : pool[$urandom_range(pool_size-1)];
                queue_request(k, $urandom_range(99) < 85);
            end
            n_random += phase_len;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || start)
            @(negedge clk);
        for (int i = 0; i < 1000 && expected_verdicts.size() != 0; i++)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (expected_verdicts.size() != 0)
            $display("%0d transactions never answered", expected_verdicts.size());
        if (failures == 0 && expected_verdicts.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* lru_hit_count_admission.f */
+incdir+src
src/lhca_pkg.sv
src/lhca_cell.sv
src/lhca_tree.sv
src/lru_hit_count_admission.sv
dv/testbench.sv
